>>> hw/rtl/gcb_pkg.sv
// Package for the grapheme cluster breaker: types, constants and the break table.
`default_nettype none
package gcb_pkg;

  localparam int POS_BITS    = 32;  // width of byte offsets inside the block
  localparam int OUT_BITS    = 32;  // width of start/length on the result bus
  localparam int CLASS_BITS  = 4;
  localparam int BYTES_BITS  = 3;
  localparam int STATE_BITS  = 3;
  localparam int ENTRY_BITS  = 5;
  localparam int NUM_STATES  = 8;
  localparam int NUM_CLASSES = 13;
  localparam int JOIN_BIT    = 4;   // entry bit set when the code point joins
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam logic [STATE_BITS-1:0] INIT_STATE   = STATE_BITS'(2);
  localparam logic [CLASS_BITS-1:0] CLASS_OTHER  = CLASS_BITS'(0);
  localparam logic [CLASS_BITS-1:0] CLASS_LIMIT  = CLASS_BITS'(NUM_CLASSES);

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [STATE_BITS-1:0] dfa_t;
  typedef logic [ENTRY_BITS-1:0] entry_t;

  typedef struct packed {
    logic [CLASS_BITS-1:0] break_class;
    logic [BYTES_BITS-1:0] char_bytes;
    logic                  end_of_text;
  } item_t;

  typedef struct packed {
    dfa_t dfa_state;
    pos_t pending_start;
    pos_t byte_position;
  } brk_state_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] cluster_start;
    logic [OUT_BITS-1:0] cluster_length;
    logic                final_result;
  } result_t;

  // Next state in bits [2:0], join flag in bit 4.
  localparam entry_t NEXT_TBL [0:NUM_STATES-1][0:NUM_CLASSES-1] = '{
    // after other / extend / spacingmark
    '{5'd0, 5'd1, 5'd2,  5'd2, 5'd3,  5'd4,  5'd4,  5'd5,  5'd5,  5'd6,  5'd7,  5'd16, 5'd16},
    // after CR
    '{5'd0, 5'd1, 5'd18, 5'd2, 5'd3,  5'd4,  5'd4,  5'd5,  5'd5,  5'd6,  5'd7,  5'd0,  5'd0},
    // after LF / control
    '{5'd0, 5'd1, 5'd2,  5'd2, 5'd3,  5'd4,  5'd4,  5'd5,  5'd5,  5'd6,  5'd7,  5'd0,  5'd0},
    // after L
    '{5'd0, 5'd1, 5'd2,  5'd2, 5'd19, 5'd20, 5'd20, 5'd21, 5'd5,  5'd6,  5'd7,  5'd16, 5'd16},
    // after V / LV
    '{5'd0, 5'd1, 5'd2,  5'd2, 5'd3,  5'd20, 5'd4,  5'd5,  5'd21, 5'd6,  5'd7,  5'd16, 5'd16},
    // after LVT / T
    '{5'd0, 5'd1, 5'd2,  5'd2, 5'd3,  5'd4,  5'd4,  5'd5,  5'd21, 5'd6,  5'd7,  5'd16, 5'd16},
    // after regional indicator
    '{5'd0, 5'd1, 5'd2,  5'd2, 5'd3,  5'd4,  5'd4,  5'd5,  5'd5,  5'd22, 5'd7,  5'd16, 5'd16},
    // after prepend
    '{5'd16, 5'd1, 5'd2, 5'd2, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd16, 5'd16, 5'd16}
  };

endpackage
`default_nettype wire

>>> hw/rtl/grapheme_cluster_breaker_unit.sv
// Top level of the grapheme cluster breaker: input register, break state, result queue.
`default_nettype none
// Path: an accepted code point is held in the input register; when it moves on, its
//   results are written to the result queue, whose head drives m_axis.
// Throughput: one code point per cycle, limited by the result port at one beat per cycle;
//   a code point that ends a string may cause two beats. s_axis stalls while a code point
//   is held and the queue holds three or more beats (room ignores this cycle's pop).
// Reset (rst, synchronous): break state to "after LF/control", positions to zero,
//   input register and result queue emptied.
// A code point with tlast set flushes the open cluster and returns the state to reset.
module grapheme_cluster_breaker_unit (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        s_axis_tvalid,
  output logic            s_axis_tready,
  input  var logic [7:0]  s_axis_tdata,  // [3:0] break_class, [6:4] char_bytes, [7] zero
  input  var logic        s_axis_tlast,  // end_of_text
  output logic            m_axis_tvalid,
  input  var logic        m_axis_tready,
  output logic [63:0]     m_axis_tdata,  // [31:0] cluster_start, [63:32] cluster_length
  output logic            m_axis_tlast   // final_result
);

  // Input register
  logic                 in_valid;
  gcb_pkg::item_t       in_item;
  logic                 advance;

  // Break state
  gcb_pkg::brk_state_t  brk;
  gcb_pkg::brk_state_t  brk_next;

  logic                 res0_valid;
  logic                 res1_valid;
  gcb_pkg::result_t     res0;
  gcb_pkg::result_t     res1;
  logic                 room2;
  gcb_pkg::result_t     head;

  // The held code point moves on whenever the queue has room for both results.
  assign advance       = in_valid && room2;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.break_class <= s_axis_tdata[3:0];
      in_item.char_bytes  <= s_axis_tdata[6:4];
      in_item.end_of_text <= s_axis_tlast;
    end
  end

  gcb_step u_step (
    .item       (in_item),
    .cur        (brk),
    .nxt        (brk_next),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      brk.dfa_state     <= gcb_pkg::INIT_STATE;
      brk.pending_start <= '0;
      brk.byte_position <= '0;
    end else if (advance) begin
      brk <= brk_next;
    end
  end

  gcb_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr0_valid (advance && res0_valid),
    .wr0       (res0),
    .wr1_valid (advance && res1_valid),
    .wr1       (res1),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_data  (head),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {head.cluster_length, head.cluster_start};
  assign m_axis_tlast = head.final_result;

endmodule
`default_nettype wire

>>> hw/rtl/gcb_step.sv
// Break decision for one code point: table lookup, position update, up to two results.
`default_nettype none
module gcb_step (
  input  var gcb_pkg::item_t      item,
  input  var gcb_pkg::brk_state_t cur,
  output gcb_pkg::brk_state_t     nxt,
  output logic                    res0_valid,
  output gcb_pkg::result_t        res0,
  output logic                    res1_valid,
  output gcb_pkg::result_t        res1
);

  logic [gcb_pkg::CLASS_BITS-1:0] cls;
  gcb_pkg::entry_t                entry;
  logic                           join_cp;
  gcb_pkg::pos_t                  start1;
  gcb_pkg::pos_t                  pos1;
  logic [gcb_pkg::POS_BITS:0]     sum;
  gcb_pkg::pos_t                  len0;
  gcb_pkg::pos_t                  len1;

  always_comb begin
    // Classes past spacingmark are treated as other.
    cls     = (item.break_class >= gcb_pkg::CLASS_LIMIT) ? gcb_pkg::CLASS_OTHER
                                                         : item.break_class;
    entry   = gcb_pkg::NEXT_TBL[cur.dfa_state][cls];
    join_cp = entry[gcb_pkg::JOIN_BIT];

    // pending_start never passes byte_position, so inequality means a
    // non-empty cluster.
    res0_valid = !join_cp && (cur.pending_start != cur.byte_position);
    len0       = cur.byte_position - cur.pending_start;
    start1     = join_cp ? cur.pending_start : cur.byte_position;

    // Saturating advance of the byte position.
    sum  = {1'b0, cur.byte_position} + (gcb_pkg::POS_BITS+1)'(item.char_bytes);
    pos1 = sum[gcb_pkg::POS_BITS] ? '1 : sum[gcb_pkg::POS_BITS-1:0];

    res1_valid = item.end_of_text && (start1 != pos1);
    len1       = pos1 - start1;

    res0.cluster_start  = gcb_pkg::OUT_BITS'(cur.pending_start);
    res0.cluster_length = gcb_pkg::OUT_BITS'(len0);
    res0.final_result   = !res1_valid;
    res1.cluster_start  = gcb_pkg::OUT_BITS'(start1);
    res1.cluster_length = gcb_pkg::OUT_BITS'(len1);
    res1.final_result   = 1'b1;

    if (item.end_of_text) begin
      nxt.dfa_state     = gcb_pkg::INIT_STATE;
      nxt.pending_start = '0;
      nxt.byte_position = '0;
    end else begin
      nxt.dfa_state     = entry[gcb_pkg::STATE_BITS-1:0];
      nxt.pending_start = start1;
      nxt.byte_position = pos1;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/gcb_out_queue.sv
// Result queue: each cycle takes up to two results, pops one on out_ready.
`default_nettype none
module gcb_out_queue (
  input  var logic             clk,
  input  var logic             rst,
  input  var logic             wr0_valid,
  input  var gcb_pkg::result_t wr0,
  input  var logic             wr1_valid,
  input  var gcb_pkg::result_t wr1,
  output logic                 room2,
  output logic                 out_valid,
  output gcb_pkg::result_t     out_data,
  input  var logic             out_ready
);

  gcb_pkg::result_t                 slots [gcb_pkg::QUEUE_DEPTH];
  logic [gcb_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [gcb_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [gcb_pkg::QCNT_BITS-1:0]    count;
  logic [gcb_pkg::QCNT_BITS-1:0]    count_next;
  logic [gcb_pkg::QCNT_BITS-1:0]    n_wr;
  logic                             pop;
  gcb_pkg::result_t                 first;

  always_comb begin
    // Room for two is judged without this cycle's pop.
    room2      = count <= gcb_pkg::QCNT_BITS'(gcb_pkg::QUEUE_DEPTH - 2);
    out_valid  = count != '0;
    out_data   = slots[rd_ptr];
    pop        = out_valid && out_ready;
    n_wr       = gcb_pkg::QCNT_BITS'(wr0_valid) + gcb_pkg::QCNT_BITS'(wr1_valid);
    first      = wr0_valid ? wr0 : wr1;
    count_next = count + n_wr - gcb_pkg::QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_wr[gcb_pkg::QPTR_BITS-1:0];
      rd_ptr <= rd_ptr + gcb_pkg::QPTR_BITS'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr0_valid || wr1_valid) begin
      slots[wr_ptr] <= first;
    end
    if (wr0_valid && wr1_valid) begin
      slots[wr_ptr + gcb_pkg::QPTR_BITS'(1)] <= wr1;
    end
  end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking testbench for grapheme_cluster_breaker_unit: directed table, random strings.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gcb_pkg::*;

  // Break classes as they travel in tdata[3:0]; the top three codes are unknown
  // and must behave like "other".
  typedef enum logic [3:0] {
    CL_OTHER, CL_CR, CL_LF, CL_CONTROL, CL_L, CL_V, CL_LV, CL_LVT, CL_T, CL_RI,
    CL_PREPEND, CL_EXTEND, CL_SPACING, CL_RSVD_D, CL_RSVD_E, CL_RSVD_F
  } gclass_e;

  // Break-state names: what the previous code point was.
  typedef enum logic [2:0] {
    ST_BASE, ST_CR, ST_CTRL, ST_L, ST_V, ST_T, ST_RI, ST_PRE
  } st_e;

  // How a stimulus row is checked: by the predictor, or by a value typed in.
  typedef enum logic [1:0] {PREDICTED, NO_CLUSTER, ONE_CLUSTER} row_check_e;

  typedef struct {
    gclass_e    cls;
    logic [2:0] nbytes;
    bit         eot;
    row_check_e how;
    logic [31:0] p_start;
    logic [31:0] p_len;
  } row_t;

  localparam int DIR_ROWS   = 24;
  localparam int RAND_ITEMS = 1700;
  localparam int LONG_HOLD  = 250;   // receiver hold-off, long enough to fill the block
  localparam int IDLE_LIMIT = 2000;  // cycles with no beat on either side
  localparam int TAIL       = 12;    // settle time after the last result

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [3:0] break_class, [6:4] char_bytes, [7] zero
  logic        s_axis_tlast = 1'b0;   // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;          // [31:0] cluster_start, [63:32] cluster_length
  logic        m_axis_tlast;          // final_result

  grapheme_cluster_breaker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // Directed strings, each starting from the reset state of the previous flush.
  // Typed rows hold results obvious from the table; the rest go through the predictor.
  row_t dir_rows [DIR_ROWS] = '{
    '{CL_OTHER,   3'd3, 1'b1, ONE_CLUSTER, 32'd0, 32'd3},  // lone char, flushed by tlast
    '{CL_CR,      3'd1, 1'b0, NO_CLUSTER,  32'd0, 32'd0},  // break at string start: empty
    '{CL_LF,      3'd1, 1'b1, ONE_CLUSTER, 32'd0, 32'd2},  // CR LF stay together
    '{CL_RSVD_F,  3'd7, 1'b1, ONE_CLUSTER, 32'd0, 32'd7},  // unknown class, odd length
    '{CL_OTHER,   3'd0, 1'b1, NO_CLUSTER,  32'd0, 32'd0},  // zero-byte string: nothing
    '{CL_PREPEND, 3'd4, 1'b0, NO_CLUSTER,  32'd0, 32'd0},
    '{CL_OTHER,   3'd2, 1'b0, PREDICTED,   32'd0, 32'd0},  // joins the prepend
    '{CL_EXTEND,  3'd1, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_CONTROL, 3'd1, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_EXTEND,  3'd1, 1'b0, PREDICTED,   32'd0, 32'd0},  // extend after control breaks
    '{CL_L,       3'd2, 1'b0, PREDICTED,   32'd0, 32'd0},  // hangul syllable run
    '{CL_V,       3'd3, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_T,       3'd4, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_LV,      3'd3, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_LVT,     3'd2, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_SPACING, 3'd1, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_RI,      3'd4, 1'b0, PREDICTED,   32'd0, 32'd0},  // all indicators in a row join
    '{CL_RI,      3'd4, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_RI,      3'd4, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_CR,      3'd1, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_CR,      3'd1, 1'b0, PREDICTED,   32'd0, 32'd0},  // CR CR breaks
    '{CL_RSVD_D,  3'd5, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_RSVD_E,  3'd6, 1'b0, PREDICTED,   32'd0, 32'd0},
    '{CL_LF,      3'd4, 1'b1, PREDICTED,   32'd0, 32'd0}   // two beats: break and flush
  };

  // Class pools that bias random strings toward the deeper table rows.
  gclass_e hangul_pool [8] = '{CL_L, CL_V, CL_T, CL_LV, CL_LVT, CL_EXTEND, CL_SPACING,
                               CL_OTHER};
  gclass_e ri_pool     [6] = '{CL_RI, CL_EXTEND, CL_PREPEND, CL_SPACING, CL_OTHER,
                               CL_CONTROL};
  gclass_e eol_pool    [5] = '{CL_CR, CL_LF, CL_OTHER, CL_EXTEND, CL_CONTROL};

  // ---------------------------------------------------------------------------
  // Predictor: break state and byte positions, advanced on every input beat.
  // ---------------------------------------------------------------------------
  st_e  brk_state = ST_CTRL;
  pos_t brk_pend  = '0;
  pos_t brk_pos   = '0;

  // State entered after a code point of class c.
  function automatic st_e class_home(gclass_e c);
    case (c)
      CL_CR:               return ST_CR;
      CL_LF, CL_CONTROL:   return ST_CTRL;
      CL_L:                return ST_L;
      CL_V, CL_LV:         return ST_V;
      CL_LVT, CL_T:        return ST_T;
      CL_RI:               return ST_RI;
      CL_PREPEND:          return ST_PRE;
      default:             return ST_BASE;
    endcase
  endfunction

  // True when a code point of class c extends the cluster opened in state st.
  function automatic bit cp_joins(st_e st, gclass_e c);
    case (st)
      ST_CR:   return c == CL_LF;
      ST_CTRL: return 1'b0;
      ST_PRE:  return !(c inside {CL_CR, CL_LF, CL_CONTROL});
      default: begin
        if (c == CL_EXTEND || c == CL_SPACING) return 1'b1;
        case (st)
          ST_L:    return c inside {CL_L, CL_V, CL_LV, CL_LVT};
          ST_V:    return c inside {CL_V, CL_T};
          ST_T:    return c == CL_T;
          ST_RI:   return c == CL_RI;
          default: return 1'b0;
        endcase
      end
    endcase
  endfunction

  // Clusters closed by one code point, in order; the last one carries the final flag.
  function automatic void predict_clusters(input logic [3:0] cls_raw, input logic [2:0] nbytes,
                                           input bit eot, output result_t outs [2],
                                           output int n);
    gclass_e       c;
    bit            join_cp;
    logic [POS_BITS:0] sum;
    n = 0;
    outs[0] = '0;
    outs[1] = '0;
    c = (cls_raw >= 4'(NUM_CLASSES)) ? CL_OTHER : gclass_e'(cls_raw);
    join_cp = cp_joins(brk_state, c);
    // prepend after prepend lands in the base state, not back in prepend
    brk_state = (brk_state == ST_PRE && c == CL_PREPEND) ? ST_BASE : class_home(c);
    if (!join_cp) begin
      if (brk_pend < brk_pos) begin
        outs[n] = '{OUT_BITS'(brk_pend), OUT_BITS'(brk_pos - brk_pend), 1'b0};
        n++;
      end
      brk_pend = brk_pos;
    end
    sum = {1'b0, brk_pos} + (POS_BITS + 1)'(nbytes);
    brk_pos = sum[POS_BITS] ? '1 : sum[POS_BITS-1:0];  // saturate at the top
    if (eot) begin
      if (brk_pend < brk_pos) begin
        outs[n] = '{OUT_BITS'(brk_pend), OUT_BITS'(brk_pos - brk_pend), 1'b0};
        n++;
      end
      brk_state = ST_CTRL;
      brk_pend  = '0;
      brk_pos   = '0;
    end
    if (n > 0) outs[n-1].final_result = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: one check entry per offered beat, expected clusters in order.
  // ---------------------------------------------------------------------------
  row_t    check_q [$];
  result_t cluster_q [$];
  row_t    cur_row;
  result_t pred_out [2];
  int      pred_n;
  result_t want;
  result_t got;

  int fails = 0;
  int beats_in = 0;
  int beats_out = 0;
  int two_beat_items = 0;
  int in_stall_cycles = 0;
  int strings_sent = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && !s_axis_tready) in_stall_cycles++;
      // Input beat first, so a result can never overtake its own expectation.
      if (s_axis_tvalid && s_axis_tready) begin
        beats_in++;
        cur_row = check_q.pop_front();
        predict_clusters(s_axis_tdata[3:0], s_axis_tdata[6:4], s_axis_tlast, pred_out, pred_n);
        if (pred_n == 2) two_beat_items++;
        case (cur_row.how)
          PREDICTED: begin
            for (int i = 0; i < pred_n; i++) cluster_q.push_back(pred_out[i]);
          end
          ONE_CLUSTER: cluster_q.push_back('{cur_row.p_start, cur_row.p_len, 1'b1});
          default: ;  // typed: nothing comes out
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        got = '{m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast};
        if (cluster_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected cluster start=%0d len=%0d last=%0b", $time,
                   got.cluster_start, got.cluster_length, got.final_result);
        end else begin
          want = cluster_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: cluster mismatch: expected start=%0d len=%0d last=%0b, got start=%0d len=%0d last=%0b",
                     $time, want.cluster_start, want.cluster_length, want.final_result,
                     got.cluster_start, got.cluster_length, got.final_result);
          end
        end
      end
    end
  end

  // Watchdog: the run is stuck when no beat moves on either side for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d clusters still expected", $time,
               IDLE_LIMIT, cluster_q.size());
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls in modes of random length; a hold-off request from the
  // sender side makes it hold ready low and refuse results.
  // ---------------------------------------------------------------------------
  int hold_req = 0;
  int hold_served = 0;

  initial begin
    int rx_mode;
    int rx_left;
    int rx_phase;
    bit rdy;
    rx_mode = 0;
    rx_left = 0;
    rx_phase = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 150);
      end
      rx_left--;
      case (rx_mode)
        0: rdy = 1'b1;                          // no stalls
        1: rdy = $urandom_range(0, 1);          // coin flip
        2: rdy = ($urandom_range(0, 3) == 0);   // mostly stalled
        default: begin                          // ready one cycle in three
          rdy = (rx_phase % 3 == 0);
          rx_phase++;
        end
      endcase
      m_axis_tready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back beats separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_cp(input row_t r);
    check_q.push_back(r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r.nbytes, r.cls};
    s_axis_tlast  <= r.eot;
    do @(posedge clk); while (!s_axis_tready);
    if (r.eot) strings_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // a gap of at least one cycle, so valid is never dropped and raised in one step
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(0, 30);
    end
  endtask

  task automatic drain_clusters();
    s_axis_tvalid <= 1'b0;
    while (cluster_q.size() != 0 || check_q.size() != 0) @(posedge clk);
  endtask

  function automatic gclass_e pick_class(int mode);
    if ($urandom_range(0, 99) < 4) return gclass_e'($urandom_range(NUM_CLASSES, 15));
    case (mode)
      1:       return hangul_pool[$urandom_range(0, 7)];
      2:       return ri_pool[$urandom_range(0, 5)];
      3:       return eol_pool[$urandom_range(0, 4)];
      default: return gclass_e'($urandom_range(0, NUM_CLASSES - 1));
    endcase
  endfunction

  initial begin
    row_t r;
    int   len;
    int   mode;
    int   rand_sent;
    bit   hold_done;
    bit   drain_done;
    rand_sent = 0;
    hold_done = 0;
    drain_done = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_cp(dir_rows[i]);
    drain_clusters();

    // Random strings: mostly well-formed lengths and classes, some noise.
    while (rand_sent < RAND_ITEMS) begin
      if (!hold_done && rand_sent >= 400) begin
        hold_req++;     // receiver holds off; sender keeps offering until the block backs up
        hold_done = 1;
        burst_left = 60;
      end
      if (!drain_done && rand_sent >= 900) begin
        drain_clusters();
        drain_done = 1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        r.cls    = pick_class(mode);
        r.nbytes = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(1, 4))
                                               : 3'($urandom_range(0, 7));
        r.eot    = (i == len - 1);
        r.how    = PREDICTED;
        r.p_start = '0;
        r.p_len   = '0;
        send_cp(r);
        rand_sent++;
      end
    end

    drain_clusters();
    repeat (TAIL) @(posedge clk);

    $display("covered %0d code points in %0d strings, %0d clusters checked (%0d two-beat items)",
             beats_in, strings_sent, beats_out, two_beat_items);
    $display("input backpressure seen on %0d cycles, %0d mismatches", in_stall_cycles, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> grapheme_cluster_breaker_unit.f
hw/rtl/gcb_pkg.sv
hw/rtl/gcb_step.sv
hw/rtl/gcb_out_queue.sv
hw/rtl/grapheme_cluster_breaker_unit.sv
bench/tb_top.sv
